// ===== hw/rtl/asrp_pkg.sv =====
package asrp_pkg;

    localparam int RateW    = 17;
    localparam int SrW      = 16;
    localparam int TickW    = 16;
    localparam int FragW    = 17;
    localparam int FcntW    = 9;
    localparam int CmdW     = 3;
    localparam int BufW     = 25;
    localparam int PendW    = 18;
    localparam int GenW     = 17;
    localparam int ThrW     = 26;
    localparam int DvdW     = 18;
    localparam int DvsW     = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 17;

    localparam int LowerShift = 13;
    localparam int RaiseShift = 12;
    localparam logic [RaiseShift:0] RaiseDiv = 13'd4095;

    localparam logic [CmdW-1:0] CMD_TICK     = 3'd0;
    localparam logic [CmdW-1:0] CMD_LEVEL    = 3'd1;
    localparam logic [CmdW-1:0] CMD_UNDERRUN = 3'd2;
    localparam logic [CmdW-1:0] CMD_UPDATE   = 3'd3;
    localparam logic [CmdW-1:0] CMD_RESTART  = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLING_RATE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TICK_RATE     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FRAG_SAMPLES  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FRAG_COUNT    = 3'd4;

    localparam logic             RST_ENABLE        = 1'b1;
    localparam logic [SrW-1:0]   RST_SAMPLING_RATE = 16'd44100;
    localparam logic [TickW-1:0] RST_TICK_RATE     = 16'd15700;
    localparam logic [FragW-1:0] RST_FRAG_SAMPLES  = 17'd256;
    localparam logic [FcntW-1:0] RST_FRAG_COUNT    = 9'd16;

    typedef struct packed {
        logic load;
        logic div_start;
        logic mul;
        logic level;
        logic raise;
        logic misc;
        logic tick;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        logic div_done;
        logic under_cond;
    } t_dp_stat;

endpackage

// ===== hw/rtl/adaptive_sample_rate_pacer.sv =====
// Paces sample generation against a tick clock and tracks an adjustable output rate.
// Items are handled one at a time and each enabled item gives one word. A tick runs
// the 18-step shift-subtract divider that forms the tick quotient; a level report
// forms the overrun threshold, checks the level and may then raise the rate; a feed
// underrun raises the rate; force update, restart and unknown commands take the misc
// step. The finished word sits in an output register, so the next item is taken
// while it waits. Disabled, items are dropped. Configuration writes are always ready.
module adaptive_sample_rate_pacer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [asrp_pkg::CmdW-1:0]     i_command,
    input  logic [asrp_pkg::BufW-1:0]     i_buffered_samples,
    input  logic                          i_delayed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [asrp_pkg::GenW-1:0]     o_generate_count,
    output logic [asrp_pkg::RateW-1:0]    o_effective_rate,
    output logic                          o_overrun_seen,
    output logic                          o_underrun_seen,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [asrp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [asrp_pkg::CfgDataW-1:0] i_cfg_data
);
    import asrp_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    asrp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stall   (i_stall),
        .i_stat    (w_stat),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_cmd     (w_cmd)
    );

    asrp_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_buffered_samples (i_buffered_samples),
        .i_delayed          (i_delayed),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_generate_count   (o_generate_count),
        .o_effective_rate   (o_effective_rate),
        .o_overrun_seen     (o_overrun_seen),
        .o_underrun_seen    (o_underrun_seen)
    );

endmodule

// ===== hw/rtl/asrp_div.sv =====
module asrp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [asrp_pkg::DvdW-1:0]  i_dividend,
    input  logic [asrp_pkg::DvsW-1:0]  i_divisor,
    output logic                       o_done,
    output logic [asrp_pkg::DvdW-1:0]  o_quotient,
    output logic [asrp_pkg::DvsW-1:0]  o_remainder
);
    import asrp_pkg::*;

    localparam int CntW = $clog2(DvdW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CntW-1:0]   r_cnt;
    logic [DvdW-1:0]   r_quo;
    logic [DvsW-1:0]   r_rem;
    logic [DvsW-1:0]   r_div;
    logic [DvsW:0]     w_part;
    logic [DvsW+1:0]   w_diff;
    logic              w_sub;

    always_comb begin
        w_part = {r_rem, r_quo[DvdW-1]};
        w_diff = {1'b0, w_part} - {2'b00, r_div};
        w_sub  = !w_diff[DvsW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DvdW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DvdW-2:0], w_sub};
            r_rem <= w_sub ? w_diff[DvsW-1:0] : w_part[DvsW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/asrp_dp.sv =====
module asrp_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [asrp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [asrp_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic [asrp_pkg::CmdW-1:0]     i_command,
    input  logic [asrp_pkg::BufW-1:0]     i_buffered_samples,
    input  logic                          i_delayed,
    input  asrp_pkg::t_dp_cmd             i_cmd,
    output asrp_pkg::t_dp_stat            o_stat,
    output logic [asrp_pkg::GenW-1:0]     o_generate_count,
    output logic [asrp_pkg::RateW-1:0]    o_effective_rate,
    output logic                          o_overrun_seen,
    output logic                          o_underrun_seen
);
    import asrp_pkg::*;

    logic              r_enable;
    logic [SrW-1:0]    r_sampling_rate;
    logic [TickW-1:0]  r_tick_rate;
    logic [FragW-1:0]  r_frag_samples;
    logic [FcntW-1:0]  r_frag_count;

    logic [RateW-1:0]  r_rate;
    logic [TickW-1:0]  r_carry;
    logic [PendW-1:0]  r_pend;
    logic              r_flag;

    logic [CmdW-1:0]   r_cmd_code;
    logic [BufW-1:0]   r_buf;
    logic              r_delayed;
    logic [ThrW-1:0]   r_thresh;
    logic [PendW-1:0]  r_gen;
    logic              r_over;
    logic              r_under;

    logic [GenW-1:0]   r_o_gen;
    logic [RateW-1:0]  r_o_rate;
    logic              r_o_over;
    logic              r_o_under;

    logic [DvsW-1:0]   w_divisor;
    logic [DvdW-1:0]   w_dividend;
    logic              w_div_done;
    logic [DvdW-1:0]   w_quo;
    logic [DvsW-1:0]   w_rem;

    logic [PendW:0]    w_sum;
    logic [PendW-1:0]  w_pend_sat;
    logic              w_hit;
    logic [FcntW-1:0]  w_frags;
    logic              w_over;
    logic              w_under;
    logic [4:0]        w_dec;
    logic [RateW-1:0]  w_low;
    logic [RateW-RaiseShift-1:0] w_q0;
    logic [RaiseShift:0]         w_r0;
    logic [5:0]        w_qr;
    logic [RateW:0]    w_raise;
    logic              w_cap_ok;
    logic [FragW:0]    w_frag_twice;

    asrp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        w_divisor  = (r_tick_rate == '0) ? DvsW'(1) : r_tick_rate;
        w_dividend = {1'b0, r_rate} + {2'b00, r_carry};

        w_sum      = {1'b0, r_pend} + {1'b0, w_quo};
        w_pend_sat = w_sum[PendW] ? {PendW{1'b1}} : w_sum[PendW-1:0];
        w_hit      = r_flag || (w_pend_sat >= {1'b0, r_frag_samples});

        w_frags = (r_frag_count >= FcntW'(2)) ? (r_frag_count - FcntW'(2)) : '0;
        w_over  = ({1'b0, r_buf} > r_thresh);
        w_frag_twice = {r_frag_samples, 1'b0};
        w_under = r_delayed && (r_buf < BufW'(w_frag_twice));

        // The rate times 8191/8192, floored, is the rate less its 8192ths rounded up.
        w_dec = 5'(r_rate[RateW-1:LowerShift]) + 5'(|r_rate[LowerShift-1:0]);
        w_low = r_rate - RateW'(w_dec);

        // The rate times 4096/4095 is the rate plus the rate divided by 4095.
        w_q0    = r_rate[RateW-1:RaiseShift];
        w_r0    = {1'b0, r_rate[RaiseShift-1:0]} + (RaiseShift+1)'(w_q0);
        w_qr    = 6'(w_q0) + 6'(w_r0 >= RaiseDiv);
        w_raise = {1'b0, r_rate} + (RateW+1)'(w_qr) + (RateW+1)'(w_qr == '0);
        w_cap_ok = (w_raise <= {1'b0, r_sampling_rate, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= RST_ENABLE;
            r_sampling_rate <= RST_SAMPLING_RATE;
            r_tick_rate     <= RST_TICK_RATE;
            r_frag_samples  <= RST_FRAG_SAMPLES;
            r_frag_count    <= RST_FRAG_COUNT;
            r_rate          <= {1'b0, RST_SAMPLING_RATE};
            r_carry         <= '0;
            r_pend          <= '0;
            r_flag          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:        r_enable        <= i_cfg_data[0];
                    CFG_SAMPLING_RATE: r_sampling_rate <= i_cfg_data[SrW-1:0];
                    CFG_TICK_RATE:     r_tick_rate     <= i_cfg_data[TickW-1:0];
                    CFG_FRAG_SAMPLES:  r_frag_samples  <= i_cfg_data[FragW-1:0];
                    CFG_FRAG_COUNT:    r_frag_count    <= i_cfg_data[FcntW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick) begin
                r_carry <= w_rem;
                if (w_hit) begin
                    r_pend <= '0;
                    r_flag <= 1'b0;
                end else begin
                    r_pend <= w_pend_sat;
                end
            end else if (i_cmd.level) begin
                r_flag <= 1'b1;
                if (w_over) begin
                    r_rate <= w_low;
                    r_pend <= '0;
                end
            end else if (i_cmd.raise) begin
                r_flag <= 1'b1;
                if (w_cap_ok) begin
                    r_rate <= w_raise[RateW-1:0];
                end
            end else if (i_cmd.misc) begin
                case (r_cmd_code)
                    CMD_UPDATE: r_flag <= 1'b1;
                    CMD_RESTART: begin
                        r_rate  <= {1'b0, r_sampling_rate};
                        r_carry <= '0;
                        r_pend  <= '0;
                        r_flag  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_code <= i_command;
            r_buf      <= i_buffered_samples;
            r_delayed  <= i_delayed;
            r_gen      <= '0;
            r_over     <= 1'b0;
            r_under    <= 1'b0;
        end else if (i_cmd.tick) begin
            if (w_hit) begin
                r_gen <= w_pend_sat;
            end
        end else if (i_cmd.level) begin
            if (w_over) begin
                r_over <= 1'b1;
            end
        end else if (i_cmd.raise) begin
            r_gen   <= {1'b0, r_frag_samples};
            r_under <= 1'b1;
        end
        if (i_cmd.mul) begin
            r_thresh <= {{(ThrW-FcntW){1'b0}}, w_frags} * {{(ThrW-FragW){1'b0}}, r_frag_samples};
        end
        if (i_cmd.emit) begin
            r_o_gen   <= r_gen[PendW-1] ? {GenW{1'b1}} : r_gen[GenW-1:0];
            r_o_rate  <= r_rate;
            r_o_over  <= r_over;
            r_o_under <= r_under;
        end
    end

    assign o_stat.enable     = r_enable;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.under_cond = w_under;

    assign o_generate_count = r_o_gen;
    assign o_effective_rate = r_o_rate;
    assign o_overrun_seen   = r_o_over;
    assign o_underrun_seen  = r_o_under;

endmodule

// ===== hw/rtl/asrp_ctrl.sv =====
module asrp_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [asrp_pkg::CmdW-1:0] i_command,
    input  logic                      i_stall,
    input  asrp_pkg::t_dp_stat        i_stat,
    output logic                      o_stall,
    output logic                      o_valid,
    output asrp_pkg::t_dp_cmd         o_cmd
);
    import asrp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVS  = 4'd1;
    localparam logic [3:0] S_DIVW  = 4'd2;
    localparam logic [3:0] S_TICK  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_LEVEL = 4'd5;
    localparam logic [3:0] S_RAISE = 4'd6;
    localparam logic [3:0] S_MISC  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_valid;
    logic       n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.enable) begin
                        case (i_command)
                            CMD_TICK:     n_state = S_DIVS;
                            CMD_LEVEL:    n_state = S_MUL;
                            CMD_UNDERRUN: n_state = S_RAISE;
                            default:      n_state = S_MISC;
                        endcase
                    end
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_TICK;
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state = S_EMIT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                o_cmd.level = 1'b1;
                n_state = i_stat.under_cond ? S_RAISE : S_EMIT;
            end
            S_RAISE: begin
                o_cmd.raise = 1'b1;
                n_state = S_EMIT;
            end
            S_MISC: begin
                o_cmd.misc = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/asrp_checker.sv =====
module asrp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [asrp_pkg::GenW-1:0]  o_generate_count,
    input logic [asrp_pkg::RateW-1:0] o_effective_rate,
    input logic                       o_overrun_seen,
    input logic                       o_underrun_seen
);

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_generate_count)
            && $stable(o_effective_rate) && $stable(o_overrun_seen)
            && $stable(o_underrun_seen))
        else $error("stalled output word changed");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("word appeared in the cycle after acceptance");

    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_effective_rate != 17'h1ffff)
        else $error("effective rate out of range");

endmodule

bind adaptive_sample_rate_pacer asrp_checker u_asrp_checker (.*);
